>>> sv/bed_pkg.sv
// Shared types and constants for the backslash escape decoder.
// No dependencies; imported by every module of the block.
package bed_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int LVL_W      = FIFO_AW + 1;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_0         = 8'h30;
  localparam logic [7:0] CH_7         = 8'h37;
  localparam logic [7:0] CH_9         = 8'h39;
  localparam logic [7:0] CH_LA        = 8'h61;
  localparam logic [7:0] CH_LB        = 8'h62;
  localparam logic [7:0] CH_LC        = 8'h63;
  localparam logic [7:0] CH_LE        = 8'h65;
  localparam logic [7:0] CH_LF        = 8'h66;
  localparam logic [7:0] CH_LN        = 8'h6E;
  localparam logic [7:0] CH_LR        = 8'h72;
  localparam logic [7:0] CH_LT        = 8'h74;
  localparam logic [7:0] CH_LV        = 8'h76;
  localparam logic [7:0] CH_LX        = 8'h78;
  localparam logic [7:0] CH_UA        = 8'h41;
  localparam logic [7:0] CH_UF        = 8'h46;

  localparam logic [7:0] CODE_BEL = 8'h07;
  localparam logic [7:0] CODE_BS  = 8'h08;
  localparam logic [7:0] CODE_ESC = 8'h1B;
  localparam logic [7:0] CODE_FF  = 8'h0C;
  localparam logic [7:0] CODE_LF  = 8'h0A;
  localparam logic [7:0] CODE_CR  = 8'h0D;
  localparam logic [7:0] CODE_HT  = 8'h09;
  localparam logic [7:0] CODE_VT  = 8'h0B;

  localparam logic [1:0] HEX_MAX_DIGITS = 2'd2;
  localparam logic [1:0] OCT_MAX_EXTRA  = 2'd3;

  typedef enum logic [2:0] {
    MODE_PLAIN,
    MODE_ESC,
    MODE_HEX,
    MODE_OCT,
    MODE_STOP
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       stopped;
    logic       end_of_string;
  } out_item_t;

  typedef struct packed {
    scan_mode_t mode;
    logic [7:0] value;
    logic [1:0] count;
  } scan_state_t;

  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

  typedef struct packed {
    push_t       push;
    scan_state_t next;
  } dec_result_t;

  typedef struct packed {
    logic             room;
    logic [LVL_W-1:0] level;
  } fifo_status_t;

  localparam scan_state_t SCAN_RESET = '{mode: MODE_PLAIN, value: 8'h00, count: 2'd0};

  function automatic out_item_t mk_item(logic [7:0] b, logic has, logic stop);
    out_item_t r;
    r.out_byte      = has ? b : 8'h00;
    r.has_byte      = has;
    r.stopped       = stop;
    r.end_of_string = 1'b0;
    return r;
  endfunction

endpackage

>>> sv/bed_decode.sv
// Decode logic for one item: current scan state and byte in, results and next state out.
// Depends on bed_pkg.
module bed_decode
  import bed_pkg::*;
(
  input  in_item_t    item,
  input  scan_state_t st,
  output dec_result_t res
);

  logic       is_hex;
  logic [3:0] hex_val;
  logic       is_oct;
  logic [1:0] cnt_inc;
  logic [7:0] b;
  out_item_t  r0;
  out_item_t  r1;
  logic [1:0] n;
  scan_state_t nxt;

  assign b       = item.in_byte;
  assign is_oct  = b inside {[CH_0:CH_7]};
  assign cnt_inc = st.count + 2'd1;

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'h0;
    if (b inside {[CH_0:CH_9]}) begin
      hex_val = 4'(b - CH_0);
    end else if (b inside {[CH_LA:CH_LF]}) begin
      hex_val = 4'(b - CH_LA + 8'd10);
    end else if (b inside {[CH_UA:CH_UF]}) begin
      hex_val = 4'(b - CH_UA + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    r0  = '0;
    r1  = '0;
    n   = 2'd0;
    nxt = st;
    case (st.mode)
      MODE_ESC: begin
        nxt.mode = MODE_PLAIN;
        n        = 2'd1;
        case (b)
          CH_LA: r0 = mk_item(CODE_BEL, 1'b1, 1'b0);
          CH_LB: r0 = mk_item(CODE_BS, 1'b1, 1'b0);
          CH_LE: r0 = mk_item(CODE_ESC, 1'b1, 1'b0);
          CH_LF: r0 = mk_item(CODE_FF, 1'b1, 1'b0);
          CH_LN: r0 = mk_item(CODE_LF, 1'b1, 1'b0);
          CH_LR: r0 = mk_item(CODE_CR, 1'b1, 1'b0);
          CH_LT: r0 = mk_item(CODE_HT, 1'b1, 1'b0);
          CH_LV: r0 = mk_item(CODE_VT, 1'b1, 1'b0);
          CH_LC: begin
            nxt.mode = MODE_STOP;
            r0       = mk_item(8'h00, 1'b0, 1'b1);
          end
          CH_LX: begin
            nxt.mode  = MODE_HEX;
            nxt.value = 8'h00;
            nxt.count = 2'd0;
            n         = 2'd0;
          end
          default: begin
            if (is_oct) begin
              nxt.mode  = MODE_OCT;
              nxt.value = {5'd0, b[2:0]};
              nxt.count = 2'd0;
              n         = 2'd0;
            end else begin
              r0 = mk_item(b, 1'b1, 1'b0);
            end
          end
        endcase
      end
      MODE_HEX, MODE_OCT: begin
        if ((st.mode == MODE_HEX) ? is_hex : is_oct) begin
          nxt.value = (st.mode == MODE_HEX) ? {st.value[3:0], hex_val}
                                            : {st.value[4:0], b[2:0]};
          nxt.count = cnt_inc;
          if (cnt_inc >= ((st.mode == MODE_HEX) ? HEX_MAX_DIGITS : OCT_MAX_EXTRA)) begin
            r0       = mk_item(nxt.value, 1'b1, 1'b0);
            n        = 2'd1;
            nxt.mode = MODE_PLAIN;
          end
        end else begin
          r0       = mk_item(st.value, 1'b1, 1'b0);
          nxt.mode = MODE_PLAIN;
          if (b != CH_BACKSLASH || item.is_last) begin
            r1 = mk_item(b, 1'b1, 1'b0);
            n  = 2'd2;
          end else begin
            nxt.mode = MODE_ESC;
            n        = 2'd1;
          end
        end
      end
      MODE_STOP: begin
      end
      default: begin
        nxt.mode = MODE_PLAIN;
        if (b != CH_BACKSLASH || item.is_last) begin
          r0 = mk_item(b, 1'b1, 1'b0);
          n  = 2'd1;
        end else begin
          nxt.mode = MODE_ESC;
        end
      end
    endcase

    if (item.is_last) begin
      if (n == 2'd0) begin
        if (nxt.mode == MODE_HEX || nxt.mode == MODE_OCT) begin
          r0 = mk_item(nxt.value, 1'b1, 1'b0);
        end else begin
          r0 = mk_item(8'h00, 1'b0, nxt.mode == MODE_STOP);
        end
        n = 2'd1;
      end
      if (n == 2'd2) begin
        r1.end_of_string = 1'b1;
      end else begin
        r0.end_of_string = 1'b1;
      end
      nxt = SCAN_RESET;
    end
  end

  assign res.push.count  = n;
  assign res.push.first  = r0;
  assign res.push.second = r1;
  assign res.next        = nxt;

endmodule

>>> sv/bed_result_fifo.sv
// Result queue: takes up to two result items per cycle, gives out one.
// Depends on bed_pkg.
module bed_result_fifo
  import bed_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  push_t        push,
  input  logic         pop,
  output out_item_t    head,
  output logic         head_valid,
  output fifo_status_t status
);

  out_item_t          mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] wr_ptr_nxt;
  logic [FIFO_AW-1:0] wr_ptr_p1;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_nxt;
  logic [LVL_W-1:0]   level_r;
  logic [LVL_W-1:0]   level_nxt;

  assign wr_ptr_p1  = FIFO_AW'(wr_ptr_r + 1'b1);
  assign wr_ptr_nxt = FIFO_AW'(wr_ptr_r + push.count);
  assign rd_ptr_nxt = pop ? FIFO_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
  assign level_nxt  = LVL_W'(level_r + LVL_W'(push.count) - LVL_W'(pop));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_p1] <= push.second;
    end
  end

  assign head         = mem[rd_ptr_r];
  assign head_valid   = (level_r != '0);
  assign status.level = level_r;
  assign status.room  = (level_r <= LVL_W'(FIFO_DEPTH - 2));

endmodule

>>> sv/backslash_escape_decoder.sv
// Top level of the backslash escape decoder: input register, scan state, result queue.
// Depends on bed_pkg, bed_decode and bed_result_fifo.
//
// Usage:
//   The input channel (in_valid, in_stall, in_item) carries one raw string byte per
//   item, with is_last set on the final byte of each string. The result channel
//   (out_valid, out_stall, out_item) carries decoded bytes; an input item gives
//   zero, one or two result items, and the last byte of a string always gives at
//   least one, the final one flagged end_of_string.
//   A result passes the input register, then the result queue, before it is offered.
//   Throughput: one input item per cycle while results drain at least as fast as
//   they are made; the input register decodes into a four-entry result queue, and
//   an item leaves the input register only when the queue has room for two.
//   Input items that make two results fill the queue faster than it drains.
//   A stalled output holds the queue head; once the queue lacks room for two, in_stall
//   rises and the held input item waits in the input register.
//   Reset clears the input valid flag, the queue and the scan state to plain text.
module backslash_escape_decoder
  import bed_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic         in_valid_r;
  logic         in_valid_nxt;
  in_item_t     in_item_r;
  scan_state_t  scan_r;
  scan_state_t  scan_nxt;
  dec_result_t  dec;
  push_t        push;
  fifo_status_t fstat;
  logic         advance;
  logic         pop;

  assign advance  = in_valid_r && fstat.room;
  assign in_stall = in_valid_r && !fstat.room;
  assign pop      = out_valid && !out_stall;

  assign in_valid_nxt = in_stall ? in_valid_r : in_valid;
  assign scan_nxt     = advance ? dec.next : scan_r;

  always_comb begin
    push = dec.push;
    if (!advance) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      scan_r     <= SCAN_RESET;
    end else begin
      in_valid_r <= in_valid_nxt;
      scan_r     <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_item_r <= in_item;
    end
  end

  bed_decode u_decode (
    .item (in_item_r),
    .st   (scan_r),
    .res  (dec)
  );

  bed_result_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .head       (out_item),
    .head_valid (out_valid),
    .status     (fstat)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fstat.level <= LVL_W'(FIFO_DEPTH))
    else $error("result queue level beyond depth");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_item_r.is_last |=> scan_r.mode == MODE_PLAIN && scan_r.count == 2'd0)
    else $error("scan state not cleared after end of string");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_item_r.is_last |-> push.count != 2'd0)
    else $error("last byte gave no result");

  a_stop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    advance && scan_r.mode == MODE_STOP && !in_item_r.is_last |-> push.count == 2'd0)
    else $error("result given after stop escape");

endmodule

>>> dv/backslash_escape_decoder_test.sv
// Self-checking test of backslash_escape_decoder: escape strings in, decoded bytes out.
// Uses bed_pkg for item types and character codes and keeps its own decoder to predict results.
// Random gaps on the input side and random stalls on the output side.
module backslash_escape_decoder_test;
  import bed_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  backslash_escape_decoder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("backslash_escape_decoder: mismatch");
    $finish;
  end

  // decoder shadow state
  scan_mode_t  mode_r = MODE_PLAIN;
  logic [11:0] value_r = '0;
  logic [1:0]  count_r = '0;
  out_item_t   step_out[2];
  int          n_out;

  out_item_t   decoded_q[$];
  logic [7:0]  text_q[$];

  bit quiet = 1'b0;
  int errors = 0;
  int items_sent = 0;
  int strings_sent = 0;
  int bytes_seen = 0;
  int stops_seen = 0;
  int stall_left = 0;

  function automatic void put(logic [7:0] b, logic has, logic stp);
    if (n_out < 2) begin
      step_out[n_out] = '{out_byte: has ? b : 8'h00, has_byte: has, stopped: stp,
                          end_of_string: 1'b0};
      n_out++;
    end
  endfunction

  function automatic int hex_val(logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  function automatic bit is_oct(logic [7:0] c);
    return c >= CH_0 && c <= CH_7;
  endfunction

  function automatic void plain_char(logic [7:0] c, logic last);
    if (c == CH_BACKSLASH) begin
      if (last) put(CH_BACKSLASH, 1'b1, 1'b0);
      else mode_r = MODE_ESC;
    end else begin
      put(c, 1'b1, 1'b0);
    end
  endfunction

  function automatic void escape_char(logic [7:0] c);
    mode_r = MODE_PLAIN;
    case (c)
      CH_LA: put(CODE_BEL, 1'b1, 1'b0);
      CH_LB: put(CODE_BS, 1'b1, 1'b0);
      CH_LE: put(CODE_ESC, 1'b1, 1'b0);
      CH_LF: put(CODE_FF, 1'b1, 1'b0);
      CH_LN: put(CODE_LF, 1'b1, 1'b0);
      CH_LR: put(CODE_CR, 1'b1, 1'b0);
      CH_LT: put(CODE_HT, 1'b1, 1'b0);
      CH_LV: put(CODE_VT, 1'b1, 1'b0);
      CH_LC: begin
        mode_r = MODE_STOP;
        put(8'h00, 1'b0, 1'b1);
      end
      CH_LX: begin
        mode_r  = MODE_HEX;
        value_r = '0;
        count_r = '0;
      end
      default: begin
        if (is_oct(c)) begin
          mode_r  = MODE_OCT;
          value_r = {4'h0, c - CH_0};
          count_r = '0;
        end else begin
          put(c, 1'b1, 1'b0);
        end
      end
    endcase
  endfunction

  function automatic void decode_byte(in_item_t it);
    logic [7:0] c;
    logic       last;
    int         d;
    out_item_t  r;
    c     = it.in_byte;
    last  = it.is_last;
    n_out = 0;
    case (mode_r)
      MODE_ESC: escape_char(c);
      MODE_HEX: begin
        d = hex_val(c);
        if (d >= 0) begin
          value_r = {value_r[7:0], d[3:0]};
          count_r = count_r + 2'd1;
          if (count_r >= HEX_MAX_DIGITS) begin
            put(value_r[7:0], 1'b1, 1'b0);
            mode_r = MODE_PLAIN;
          end
        end else begin
          put(value_r[7:0], 1'b1, 1'b0);
          mode_r = MODE_PLAIN;
          plain_char(c, last);
        end
      end
      MODE_OCT: begin
        if (is_oct(c)) begin
          value_r = {value_r[8:0], c[2:0]};
          count_r = count_r + 2'd1;
          if (count_r >= OCT_MAX_EXTRA) begin
            put(value_r[7:0], 1'b1, 1'b0);
            mode_r = MODE_PLAIN;
          end
        end else begin
          put(value_r[7:0], 1'b1, 1'b0);
          mode_r = MODE_PLAIN;
          plain_char(c, last);
        end
      end
      MODE_STOP: ;
      default: begin
        mode_r = MODE_PLAIN;
        plain_char(c, last);
      end
    endcase
    if (last) begin
      if (mode_r == MODE_HEX || mode_r == MODE_OCT) put(value_r[7:0], 1'b1, 1'b0);
      if (n_out == 0) put(8'h00, 1'b0, mode_r == MODE_STOP);
    end
    for (int k = 0; k < n_out; k++) begin
      r = step_out[k];
      r.end_of_string = last && (k == n_out - 1);
      decoded_q.push_back(r);
    end
    if (last) begin
      mode_r  = MODE_PLAIN;
      value_r = '0;
      count_r = '0;
    end
  endfunction

  function automatic void report(string what, out_item_t want, out_item_t got);
    errors++;
    if (errors <= 10)
      $display("%0t %s: want byte=%h has=%b stop=%b eos=%b, got byte=%h has=%b stop=%b eos=%b",
               $realtime, what, want.out_byte, want.has_byte, want.stopped, want.end_of_string,
               got.out_byte, got.has_byte, got.stopped, got.end_of_string);
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) decode_byte(in_item);
      if (out_valid && !out_stall) begin
        if (out_item.has_byte) bytes_seen++;
        if (out_item.stopped) stops_seen++;
        if (decoded_q.size() == 0) begin
          report("unexpected item", '0, out_item);
        end else begin
          want = decoded_q.pop_front();
          if (out_item.out_byte !== want.out_byte || out_item.has_byte !== want.has_byte ||
              out_item.stopped !== want.stopped ||
              out_item.end_of_string !== want.end_of_string)
            report("wrong item", want, out_item);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      stall_left <= pick_gap();
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{in_byte: b, is_last: last};
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    strings_sent++;
    text_q.delete();
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'(CH_0 + v);
    if (v < 16) return 8'(CH_LA + v - 10);
    return 8'(CH_UA + v - 16);
  endfunction

  function automatic void add_token();
    logic [7:0] letters[8] = '{CH_LA, CH_LB, CH_LE, CH_LF, CH_LN, CH_LR, CH_LT, CH_LV};
    int         r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      text_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    text_q.push_back(CH_BACKSLASH);
    if (r < 48) begin
      text_q.push_back(letters[$urandom_range(0, 7)]);
    end else if (r < 66) begin
      text_q.push_back(CH_LX);
      repeat ($urandom_range(0, 3)) text_q.push_back(rand_hex_char());
    end else if (r < 84) begin
      repeat ($urandom_range(1, 5)) text_q.push_back(8'(CH_0 + $urandom_range(0, 7)));
    end else if (r < 88) begin
      text_q.push_back(CH_LC);
    end else if (r < 97) begin
      text_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void build_escape_string();
    repeat ($urandom_range(1, 6)) add_token();
  endfunction

  function automatic void build_noise_string();
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 3) == 0) text_q.push_back(CH_BACKSLASH);
      else text_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic test_directed();
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    send_text();
    send_str("\\e\\v\\\"");
    send_str("\\x4g\\xF");
    send_str("\\7777\\18\\");
    send_str("a\\cbz");
    send_str("\\x");
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    repeat (30) begin
      build_escape_string();
      send_text();
    end
    quiet = 1'b0;
  endtask

  task automatic test_random_strings();
    repeat (60) begin
      build_escape_string();
      send_text();
    end
  endtask

  task automatic test_drain_pause();
    wait_drained();
    repeat (20) begin
      build_escape_string();
      send_text();
    end
  endtask

  task automatic test_noise();
    repeat (40) begin
      build_noise_string();
      send_text();
    end
  endtask

  task automatic finish_run();
    wait_drained();
    repeat (10) @(posedge clk);
    $display("sent %0d bytes in %0d strings; checked %0d decoded bytes, %0d stop items",
             items_sent, strings_sent, bytes_seen, stops_seen);
    if (errors == 0 && decoded_q.size() == 0) begin
      $display("backslash_escape_decoder: match");
    end else begin
      $display("errors: %0d, items still expected: %0d", errors, decoded_q.size());
      $display("backslash_escape_decoder: mismatch");
    end
    $finish;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_back_to_back();
    test_random_strings();
    test_drain_pause();
    test_noise();
    test_random_strings();
    finish_run();
  end

endmodule
